>>> sv/vbtu_pkg.sv
// Shared types, constants and codes of the vCPU breakpoint and trace unit.
package vbtu_pkg;

    // Sizes of the per-vCPU state.
    localparam int NUM_VCPUS = 4;
    localparam int MAX_BP    = 8;

    localparam int VIDX_W = (NUM_VCPUS > 1) ? $clog2(NUM_VCPUS) : 1;
    localparam int SLOT_W = (MAX_BP > 1) ? $clog2(MAX_BP) : 1;
    localparam int CNT_W  = $clog2(MAX_BP + 1);

    // Fixed field widths of the stream words.
    localparam int CMD_W      = 3;
    localparam int VCPU_W     = 2;
    localparam int ADDR_W     = 32;
    localparam int BSLOT_W    = 8;
    localparam int OPC_W      = 8;
    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 16;
    localparam int FLAGS_W    = 5;

    // Configuration register indexes.
    localparam int REG_IDX_W = 1;
    localparam logic [REG_IDX_W-1:0] REG_SYSCALL_OPC = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_RET_OPC     = 1'd1;

    // Bit positions of the trace flags.
    localparam int FL_STEP = 0;
    localparam int FL_CONT = 1;
    localparam int FL_SYSC = 2;
    localparam int FL_RET  = 3;
    localparam int FL_DEAD = 4;

    typedef enum logic [2:0] {
        CMD_CHECK    = 3'd0,
        CMD_ADD_BP   = 3'd1,
        CMD_DEL_BP   = 3'd2,
        CMD_STEP     = 3'd3,
        CMD_CONTINUE = 3'd4,
        CMD_TO_SYSC  = 3'd5,
        CMD_TO_RET   = 3'd6,
        CMD_DEAD     = 3'd7
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_IDLE     = 3'd1,
        ST_NO_DEBUG = 3'd2,
        ST_BEYOND   = 3'd3,
        ST_FULL     = 3'd4,
        ST_BAD      = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        RSN_NONE    = 3'd0,
        RSN_BP      = 3'd1,
        RSN_SYSCALL = 3'd2,
        RSN_RET     = 3'd3,
        RSN_TRACE   = 3'd4,
        RSN_DEAD    = 3'd5
    } reason_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_FINISH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic idx_load;
        logic mem_rd;
        logic scan_cmp;
        logic shift_wr;
        logic commit;
    } ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_scan;
        logic need_shift;
        logic idx_end;
        logic cmp_hit;
        logic out_free;
    } stat_t;

endpackage

>>> sv/vbtu_ctrl.sv
// Sequencer of the vCPU breakpoint and trace unit: decode, table scan, compaction, commit.
module vbtu_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    input  vbtu_pkg::stat_t stat,
    output vbtu_pkg::ctl_t  ctl
);

    vbtu_pkg::state_t state_reg;
    vbtu_pkg::state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vbtu_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            vbtu_pkg::S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = vbtu_pkg::S_DECODE;
                end
            end
            vbtu_pkg::S_DECODE:
            begin
                priority if (stat.need_scan)
                begin
                    state_next = vbtu_pkg::S_SCAN_RD;
                end
                else if (stat.need_shift)
                begin
                    state_next = vbtu_pkg::S_SHIFT_RD;
                end
                else
                begin
                    state_next = vbtu_pkg::S_FINISH;
                end
            end
            vbtu_pkg::S_SCAN_RD:
            begin
                state_next = stat.idx_end ? vbtu_pkg::S_FINISH : vbtu_pkg::S_SCAN_CMP;
            end
            vbtu_pkg::S_SCAN_CMP:
            begin
                state_next = stat.cmp_hit ? vbtu_pkg::S_FINISH : vbtu_pkg::S_SCAN_RD;
            end
            vbtu_pkg::S_SHIFT_RD:
            begin
                state_next = stat.idx_end ? vbtu_pkg::S_FINISH : vbtu_pkg::S_SHIFT_WR;
            end
            vbtu_pkg::S_SHIFT_WR:
            begin
                state_next = vbtu_pkg::S_SHIFT_RD;
            end
            vbtu_pkg::S_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = vbtu_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = vbtu_pkg::S_IDLE;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb
    begin
        s_axis_tready = (state_reg == vbtu_pkg::S_IDLE);
        ctl.load      = (state_reg == vbtu_pkg::S_IDLE) && s_axis_tvalid;
        ctl.idx_load  = (state_reg == vbtu_pkg::S_DECODE);
        ctl.mem_rd    = ((state_reg == vbtu_pkg::S_SCAN_RD) ||
                         (state_reg == vbtu_pkg::S_SHIFT_RD)) && !stat.idx_end;
        ctl.scan_cmp  = (state_reg == vbtu_pkg::S_SCAN_CMP);
        ctl.shift_wr  = (state_reg == vbtu_pkg::S_SHIFT_WR);
        ctl.commit    = (state_reg == vbtu_pkg::S_FINISH) && stat.out_free;
    end

endmodule

>>> sv/vbtu_dp.sv
// Datapath of the vCPU breakpoint and trace unit: item registers, tables, decision, result.
module vbtu_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [vbtu_pkg::REG_IDX_W-1:0]       cfg_index,
    input  logic [vbtu_pkg::OPC_W-1:0]           cfg_data,
    input  logic [vbtu_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    input  logic [vbtu_pkg::CMD_W-1:0]           s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [vbtu_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    input  vbtu_pkg::ctl_t                       ctl,
    output vbtu_pkg::stat_t                      stat
);

    // Configuration registers.
    logic [vbtu_pkg::OPC_W-1:0] sys_opc_reg;
    logic [vbtu_pkg::OPC_W-1:0] ret_opc_reg;

    // Registered input word.
    vbtu_pkg::cmd_t               cmd_reg;
    logic [vbtu_pkg::VCPU_W-1:0]  vcpu_reg;
    logic [vbtu_pkg::ADDR_W-1:0]  addr_reg;
    logic [vbtu_pkg::BSLOT_W-1:0] slot_reg;
    logic [vbtu_pkg::OPC_W-1:0]   opc_reg;
    logic [vbtu_pkg::ADDR_W-1:0]  csize_reg;
    logic                         used_reg;
    logic                         dbg_reg;

    // Per-vCPU state.
    logic [vbtu_pkg::CNT_W-1:0]   cnt_reg     [vbtu_pkg::NUM_VCPUS];
    logic [vbtu_pkg::FLAGS_W-1:0] flags_reg   [vbtu_pkg::NUM_VCPUS];
    logic                         stopped_reg [vbtu_pkg::NUM_VCPUS];

    // Breakpoint table memory.
    logic [vbtu_pkg::ADDR_W-1:0]  bp_mem [vbtu_pkg::NUM_VCPUS][vbtu_pkg::MAX_BP];
    logic [vbtu_pkg::ADDR_W-1:0]  rd_data_reg;

    // Walk index and scan result.
    logic [vbtu_pkg::CNT_W-1:0]   idx_reg;
    logic                         found_reg;
    logic [vbtu_pkg::SLOT_W-1:0]  hit_reg;

    // Result register.
    logic                              m_valid_reg;
    logic [vbtu_pkg::OUT_DATA_W-1:0]   out_data_reg;

    // Derived values.
    logic [vbtu_pkg::VIDX_W-1:0]  vidx;
    logic                         bad_vcpu;
    logic [vbtu_pkg::CNT_W-1:0]   n;
    logic [vbtu_pkg::FLAGS_W-1:0] f;
    logic                         slot_ok;
    logic                         addr_in_code;
    logic [vbtu_pkg::SLOT_W-1:0]  rd_slot;
    logic [vbtu_pkg::SLOT_W-1:0]  shift_wr_slot;

    // Decision outputs.
    vbtu_pkg::status_t            res_status;
    vbtu_pkg::reason_t            res_reason;
    logic                         res_proceed;
    logic                         res_destroy;
    logic [vbtu_pkg::CNT_W-1:0]   cnt_new;
    logic [vbtu_pkg::FLAGS_W-1:0] flags_new;
    logic                         stopped_new;
    logic                         add_wr;
    logic [vbtu_pkg::OUT_DATA_W-1:0] res_word;

    assign vidx          = vbtu_pkg::VIDX_W'(vcpu_reg);
    assign bad_vcpu      = (32'(vcpu_reg) >= 32'(vbtu_pkg::NUM_VCPUS));
    assign n             = cnt_reg[vidx];
    assign f             = flags_reg[vidx];
    assign slot_ok       = (32'(slot_reg) < 32'(n)) && (32'(slot_reg) < 32'(vbtu_pkg::MAX_BP));
    assign addr_in_code  = (addr_reg < csize_reg);
    assign rd_slot       = vbtu_pkg::SLOT_W'(idx_reg);
    assign shift_wr_slot = vbtu_pkg::SLOT_W'(idx_reg - vbtu_pkg::CNT_W'(1));

    // Status to the controller.
    always_comb
    begin
        stat.need_scan  = !bad_vcpu &&
                          (((cmd_reg == vbtu_pkg::CMD_CHECK) &&
                            !f[vbtu_pkg::FL_DEAD] && !f[vbtu_pkg::FL_STEP]) ||
                           ((cmd_reg == vbtu_pkg::CMD_ADD_BP) &&
                            used_reg && dbg_reg && addr_in_code));
        stat.need_shift = !bad_vcpu && (cmd_reg == vbtu_pkg::CMD_DEL_BP) &&
                          used_reg && dbg_reg && slot_ok;
        stat.idx_end    = (idx_reg >= n);
        stat.cmp_hit    = (rd_data_reg == addr_reg);
        stat.out_free   = !m_valid_reg || m_axis_tready;
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sys_opc_reg <= '0;
            ret_opc_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                vbtu_pkg::REG_SYSCALL_OPC: sys_opc_reg <= cfg_data;
                vbtu_pkg::REG_RET_OPC:     ret_opc_reg <= cfg_data;
                default:                   sys_opc_reg <= sys_opc_reg;
            endcase
        end
    end

    // Input word capture; fields are unpacked from the lowest bit up.
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg   <= vbtu_pkg::cmd_t'(s_axis_tuser);
            vcpu_reg  <= s_axis_tdata[1:0];
            addr_reg  <= s_axis_tdata[33:2];
            slot_reg  <= s_axis_tdata[41:34];
            opc_reg   <= s_axis_tdata[49:42];
            csize_reg <= s_axis_tdata[81:50];
            used_reg  <= s_axis_tdata[82];
            dbg_reg   <= s_axis_tdata[83];
        end
    end

    // Walk index: scans start at slot zero, compaction one past the deleted slot.
    always_ff @(posedge clk)
    begin
        if (ctl.idx_load)
        begin
            idx_reg <= stat.need_scan ? '0
                                      : vbtu_pkg::CNT_W'(slot_reg) + vbtu_pkg::CNT_W'(1);
        end
        else if ((ctl.scan_cmp && !stat.cmp_hit) || ctl.shift_wr)
        begin
            idx_reg <= idx_reg + vbtu_pkg::CNT_W'(1);
        end
    end

    // Scan result.
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            found_reg <= 1'b0;
            hit_reg   <= '0;
        end
        else if (ctl.scan_cmp && stat.cmp_hit)
        begin
            found_reg <= 1'b1;
            hit_reg   <= rd_slot;
        end
    end

    // Breakpoint table: one registered read port, one write port.
    always_ff @(posedge clk)
    begin
        if (ctl.mem_rd)
        begin
            rd_data_reg <= bp_mem[vidx][rd_slot];
        end
        if (ctl.shift_wr)
        begin
            bp_mem[vidx][shift_wr_slot] <= rd_data_reg;
        end
        else if (ctl.commit && add_wr)
        begin
            bp_mem[vidx][vbtu_pkg::SLOT_W'(n)] <= addr_reg;
        end
    end

    // Decision for the item held in the registers.
    always_comb
    begin
        res_status  = vbtu_pkg::ST_OK;
        res_reason  = vbtu_pkg::RSN_NONE;
        res_proceed = 1'b0;
        res_destroy = 1'b0;
        cnt_new     = n;
        flags_new   = f;
        stopped_new = stopped_reg[vidx];
        add_wr      = 1'b0;
        priority if (bad_vcpu)
        begin
            res_status = vbtu_pkg::ST_BAD;
        end
        else if (cmd_reg == vbtu_pkg::CMD_CHECK)
        begin
            priority if (f[vbtu_pkg::FL_DEAD])
            begin
                res_destroy = 1'b1;
                res_reason  = vbtu_pkg::RSN_DEAD;
            end
            else if (f[vbtu_pkg::FL_STEP])
            begin
                flags_new[vbtu_pkg::FL_STEP] = 1'b0;
                res_proceed = 1'b1;
            end
            else if (found_reg)
            begin
                res_reason = vbtu_pkg::RSN_BP;
            end
            else if (f[vbtu_pkg::FL_SYSC])
            begin
                if (opc_reg == sys_opc_reg)
                begin
                    res_reason = vbtu_pkg::RSN_SYSCALL;
                end
                else
                begin
                    res_proceed = 1'b1;
                end
            end
            else if (f[vbtu_pkg::FL_RET])
            begin
                if (opc_reg == ret_opc_reg)
                begin
                    res_reason = vbtu_pkg::RSN_RET;
                end
                else
                begin
                    res_proceed = 1'b1;
                end
            end
            else if (f[vbtu_pkg::FL_CONT])
            begin
                res_proceed = 1'b1;
            end
            else
            begin
                res_reason = vbtu_pkg::RSN_TRACE;
            end
            // Any stop other than a dead vCPU halts it and drops the trace mode.
            if ((res_reason != vbtu_pkg::RSN_NONE) && (res_reason != vbtu_pkg::RSN_DEAD))
            begin
                stopped_new = 1'b1;
                flags_new   = '0;
            end
        end
        else if (!used_reg)
        begin
            res_status = vbtu_pkg::ST_IDLE;
        end
        else if ((cmd_reg == vbtu_pkg::CMD_ADD_BP) || (cmd_reg == vbtu_pkg::CMD_DEL_BP))
        begin
            priority if (!dbg_reg)
            begin
                res_status = vbtu_pkg::ST_NO_DEBUG;
            end
            else if (cmd_reg == vbtu_pkg::CMD_ADD_BP)
            begin
                priority if (!addr_in_code)
                begin
                    res_status = vbtu_pkg::ST_BEYOND;
                end
                else if (!found_reg)
                begin
                    if (32'(n) >= 32'(vbtu_pkg::MAX_BP))
                    begin
                        res_status = vbtu_pkg::ST_FULL;
                    end
                    else
                    begin
                        add_wr  = 1'b1;
                        cnt_new = n + vbtu_pkg::CNT_W'(1);
                    end
                end
                else
                begin
                    // Address already in the table: nothing to do.
                    res_status = vbtu_pkg::ST_OK;
                end
            end
            else
            begin
                if (!slot_ok)
                begin
                    res_status = vbtu_pkg::ST_BAD;
                end
                else
                begin
                    cnt_new = n - vbtu_pkg::CNT_W'(1);
                end
            end
        end
        else if (cmd_reg == vbtu_pkg::CMD_DEAD)
        begin
            flags_new[vbtu_pkg::FL_DEAD] = 1'b1;
        end
        else
        begin
            // Step, continue, run to syscall, run to return.
            if (!stopped_reg[vidx])
            begin
                res_status = vbtu_pkg::ST_BAD;
            end
            else
            begin
                stopped_new = 1'b0;
                flags_new[vbtu_pkg::FL_STEP] = 1'b1;
                if (cmd_reg == vbtu_pkg::CMD_CONTINUE)
                begin
                    flags_new[vbtu_pkg::FL_CONT] = 1'b1;
                end
                else if (cmd_reg == vbtu_pkg::CMD_TO_SYSC)
                begin
                    flags_new[vbtu_pkg::FL_SYSC] = 1'b1;
                end
                else if (cmd_reg == vbtu_pkg::CMD_TO_RET)
                begin
                    flags_new[vbtu_pkg::FL_RET] = 1'b1;
                end
            end
        end
    end

    // Result word, from the highest bit down.
    assign res_word = {1'b0,
                       bad_vcpu ? 4'd0 : 4'(cnt_new),
                       res_destroy,
                       (found_reg && (cmd_reg == vbtu_pkg::CMD_CHECK) && !bad_vcpu)
                           ? 3'(hit_reg) : 3'd0,
                       res_reason,
                       res_proceed,
                       res_status};

    // Per-vCPU state update at commit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < vbtu_pkg::NUM_VCPUS; i++)
            begin
                cnt_reg[i]     <= '0;
                flags_reg[i]   <= '0;
                stopped_reg[i] <= 1'b0;
            end
        end
        else if (ctl.commit && !bad_vcpu)
        begin
            cnt_reg[vidx]     <= cnt_new;
            flags_reg[vidx]   <= flags_new;
            stopped_reg[vidx] <= stopped_new;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (ctl.commit)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.commit)
        begin
            out_data_reg <= res_word;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // A result is only written into a free or draining output register.
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.commit |-> (!m_valid_reg || m_axis_tready))
        else $error("result committed over an unread word");

    // A committed result is offered in the next cycle.
    a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.commit |=> m_valid_reg)
        else $error("committed result not presented");

    // Compaction only moves entries that lie inside the held table.
    a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.shift_wr |-> ((idx_reg != '0) && (idx_reg < n)))
        else $error("compaction index outside the table");

    // Table reads stay below the entry count.
    a_read_range: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.mem_rd |-> (idx_reg < n))
        else $error("breakpoint read beyond the entry count");

endmodule

>>> sv/vcpu_breakpoint_trace_unit.sv
// Top level of the vCPU breakpoint and trace unit.
// Without a table walk a word goes through accept, decode and finish; a scan (check, add) reads
// and compares the held breakpoints in turn until a hit, and a delete moves each later entry down one slot.
// One word at a time: the next is accepted the cycle after the last result is written, and a
// result is written only once the output register is free or draining.
// Reset (rst_n low, async) clears counts, trace flags, stopped bits, opcode registers and output valid only.
module vcpu_breakpoint_trace_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration write port.
    input  logic                              cfg_we,
    input  logic [vbtu_pkg::REG_IDX_W-1:0]    cfg_index,
    input  logic [vbtu_pkg::OPC_W-1:0]        cfg_data,
    // Input words.
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata: vcpu[1:0], address[33:2], bp_slot[41:34], opcode[49:42], code_size[81:50],
    //        vcpu_in_use[82], vcpu_debug_enabled[83], zero[87:84]
    input  logic [vbtu_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // tuser: cmd[2:0]
    input  logic [vbtu_pkg::CMD_W-1:0]        s_axis_tuser,
    // Result words.
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata: status[2:0], proceed[3], stop_reason[6:4], hit_slot[9:7], destroy_request[10],
    //        bp_count_out[14:11], zero[15]
    output logic [vbtu_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

    vbtu_pkg::ctl_t  ctl;
    vbtu_pkg::stat_t stat;

    // Sequencer.
    vbtu_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .stat          (stat),
        .ctl           (ctl)
    );

    // Tables, decision and result register.
    vbtu_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .ctl           (ctl),
        .stat          (stat)
    );

endmodule
